@@ design/jkre_pkg.sv @@
// Shared types, key codes and keysym table for the joystick/key event block.
package jkre_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Input item kinds carried on tuser
    localparam logic FUNC_JOY = 1'b0;
    localparam logic FUNC_KEY = 1'b1;

    // Key codes
    localparam logic [7:0] KC_RETURN = 8'h0D;
    localparam logic [7:0] KC_DELETE = 8'h14;
    localparam logic [7:0] KC_UP     = 8'h91;
    localparam logic [7:0] KC_DOWN   = 8'h11;
    localparam logic [7:0] KC_LEFT   = 8'h9D;
    localparam logic [7:0] KC_RIGHT  = 8'h1D;
    localparam logic [7:0] KC_F1     = 8'h85;
    localparam logic [7:0] KC_F3     = 8'h86;
    localparam logic [7:0] KC_F5     = 8'h87;
    localparam logic [7:0] KC_F7     = 8'h88;

    // Keysyms
    localparam logic [15:0] KS_BACKSPACE = 16'hFF08;
    localparam logic [15:0] KS_UP        = 16'hFF52;
    localparam logic [15:0] KS_LEFT      = 16'hFF51;
    localparam logic [15:0] KS_DOWN      = 16'hFF54;
    localparam logic [15:0] KS_RIGHT     = 16'hFF53;

    // Pointer button masks
    localparam logic [2:0] BTN_LEFT   = 3'd1;
    localparam logic [2:0] BTN_MIDDLE = 3'd2;
    localparam logic [2:0] BTN_RIGHT  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STEP   = 2'd2;

    // Reset values
    localparam logic [15:0] RST_WIDTH  = 16'd640;
    localparam logic [15:0] RST_HEIGHT = 16'd480;
    localparam logic [7:0]  RST_STEP   = 8'd8;

    // One classified item: every event of it carries the same cursor and mode
    typedef struct packed {
        logic        is_key;
        logic [1:0]  num_ev;   // 0 to 3; 1 to 3 once queued
        logic [2:0]  mask;     // click buttons, pointer only
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] keysym;
        logic        mode;
    } t_cmd;

    function automatic logic [15:0] translate(input logic [7:0] c);
        logic [15:0] sym;
        sym = 16'd0;
        case (c)
            KC_RETURN: sym = 16'h000D;
            KC_DELETE: sym = KS_BACKSPACE;
            KC_UP:     sym = KS_UP;
            KC_LEFT:   sym = KS_LEFT;
            KC_DOWN:   sym = KS_DOWN;
            KC_RIGHT:  sym = KS_RIGHT;
            default: begin
                if (c >= 8'h41 && c <= 8'h5A) begin
                    sym = {8'd0, c + 8'h20};
                end else if (c >= 8'h20 && c <= 8'h60) begin
                    sym = {8'd0, c};
                end
            end
        endcase
        return sym;
    endfunction

endpackage

@@ design/jkre_front.sv @@
// Front end: takes input beats, updates cursor/mode state, emits commands.
module jkre_front
    import jkre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_func,
    input  logic [4:0]  i_joy,
    input  logic [7:0]  i_key,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0] r_width, r_height, r_lim_x, r_lim_y;
    logic [7:0]  r_step;
    logic [15:0] r_cx, r_cy;
    logic        r_mode, r_fire_held;

    logic [15:0] n_cx, n_cy;
    logic        n_mode, n_fire_held;
    logic        accept;

    function automatic logic [15:0] dec_sat(input logic [15:0] v, input logic [7:0] s);
        logic [16:0] d;
        d = {1'b0, v} - {9'd0, s};
        return d[16] ? 16'd0 : d[15:0];
    endfunction

    function automatic logic [15:0] inc_clamp(input logic [15:0] v, input logic [7:0] s,
                                              input logic [15:0] lim);
        logic [16:0] a;
        a = {1'b0, v} + {9'd0, s};
        return (a > {1'b0, lim}) ? lim : a[15:0];
    endfunction

    function automatic logic [15:0] limit_of(input logic [15:0] size);
        return (size == 16'd0) ? 16'd0 : size - 16'd1;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        logic [15:0] y1, x1;
        logic        moved, fire, click;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_mode      = r_mode;
        n_fire_held = r_fire_held;
        o_cmd        = '0;
        o_cmd.mode   = r_mode;
        y1 = r_cy;
        x1 = r_cx;
        moved = 1'b0;
        fire  = 1'b0;
        click = 1'b0;
        if (i_func == FUNC_JOY) begin
            if (i_joy != 5'd0) begin
                // directions apply in order up, down, left, right
                y1   = i_joy[0] ? r_cy : dec_sat(r_cy, r_step);
                n_cy = i_joy[1] ? y1 : inc_clamp(y1, r_step, r_lim_y);
                x1   = i_joy[2] ? r_cx : dec_sat(r_cx, r_step);
                n_cx = i_joy[3] ? x1 : inc_clamp(x1, r_step, r_lim_x);
                moved = (i_joy[3:0] != 4'hF);
                fire  = !i_joy[4];
                click = fire && !r_fire_held;
                n_fire_held = fire;
                o_cmd.mask   = BTN_LEFT;
                o_cmd.num_ev = {click, moved};
            end
        end else if (i_key == KC_F7) begin
            n_mode = !r_mode;
        end else if (r_mode) begin
            unique case (i_key) inside
                KC_UP: begin
                    n_cy = dec_sat(r_cy, r_step);
                    o_cmd.num_ev = 2'd1;
                end
                KC_DOWN: begin
                    n_cy = inc_clamp(r_cy, r_step, r_lim_y);
                    o_cmd.num_ev = 2'd1;
                end
                KC_LEFT: begin
                    n_cx = dec_sat(r_cx, r_step);
                    o_cmd.num_ev = 2'd1;
                end
                KC_RIGHT: begin
                    n_cx = inc_clamp(r_cx, r_step, r_lim_x);
                    o_cmd.num_ev = 2'd1;
                end
                KC_RETURN, KC_F1: begin
                    o_cmd.mask   = BTN_LEFT;
                    o_cmd.num_ev = 2'd2;
                end
                KC_F3: begin
                    o_cmd.mask   = BTN_MIDDLE;
                    o_cmd.num_ev = 2'd2;
                end
                KC_F5: begin
                    o_cmd.mask   = BTN_RIGHT;
                    o_cmd.num_ev = 2'd2;
                end
                default: ;
            endcase
        end else begin
            o_cmd.is_key = 1'b1;
            o_cmd.keysym = translate(i_key);
            o_cmd.num_ev = (o_cmd.keysym != 16'd0) ? 2'd2 : 2'd0;
        end
        o_cmd.pos_x = n_cx;
        o_cmd.pos_y = n_cy;
        o_cmd.mode  = n_mode;
    end

    assign o_push = accept && (o_cmd.num_ev != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_lim_x     <= limit_of(RST_WIDTH);
            r_lim_y     <= limit_of(RST_HEIGHT);
            r_step      <= RST_STEP;
            r_cx        <= RST_WIDTH >> 1;
            r_cy        <= RST_HEIGHT >> 1;
            r_mode      <= 1'b1;
            r_fire_held <= 1'b0;
        end else if (i_cfg_wen) begin
            // any known register write recenters the cursor
            unique case (i_cfg_idx)
                CFG_WIDTH: begin
                    r_width <= i_cfg_data;
                    r_lim_x <= limit_of(i_cfg_data);
                    r_cx    <= i_cfg_data >> 1;
                    r_cy    <= r_height >> 1;
                end
                CFG_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_lim_y  <= limit_of(i_cfg_data);
                    r_cx     <= r_width >> 1;
                    r_cy     <= i_cfg_data >> 1;
                end
                CFG_STEP: begin
                    r_step <= i_cfg_data[7:0];
                    r_cx   <= r_width >> 1;
                    r_cy   <= r_height >> 1;
                end
                default: ;
            endcase
        end else if (accept) begin
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_mode      <= n_mode;
            r_fire_held <= n_fire_held;
        end
    end

endmodule

@@ design/jkre_fifo.sv @@
// Short command queue between the front end and the event generator.
module jkre_fifo
    import jkre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_AW:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

@@ design/jkre_back.sv @@
// Back end: expands queued commands into one event beat per cycle while the output is ready.
module jkre_back
    import jkre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic        r_is_key, r_last, r_down, r_mode;
    logic [2:0]  r_mask;
    logic [15:0] r_x, r_y, r_sym;

    logic load, ev_last, first;

    assign load    = i_valid && (!r_valid || i_m_tready);
    assign ev_last = (r_idx == i_cmd.num_ev - 2'd1);
    assign first   = (r_idx == 2'd0);
    assign o_pop   = load && ev_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= ev_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // A click is press then release; a pointer command of one event is a move
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_key <= i_cmd.is_key;
            r_mask   <= (!i_cmd.is_key && i_cmd.num_ev[1] && first) ? i_cmd.mask : 3'd0;
            r_x      <= i_cmd.is_key ? 16'd0 : i_cmd.pos_x;
            r_y      <= i_cmd.is_key ? 16'd0 : i_cmd.pos_y;
            r_down   <= i_cmd.is_key && first;
            r_sym    <= i_cmd.is_key ? i_cmd.keysym : 16'd0;
            r_mode   <= i_cmd.mode;
            r_last   <= ev_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_is_key;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {3'd0, r_mode, r_sym, r_down, r_y, r_x, r_mask};

endmodule

@@ design/joystick_key_to_remote_input_events.sv @@
// Top level: joystick/key items in, remote pointer and key events out.
//
//  channel  dir  handshake        tdata (low bit up)                      tuser     tlast
//  s        in   tvalid/tready    joy_lines[4:0], key_code[12:5]          func      -
//  m        out  tvalid/tready    buttons[2:0], pos_x[18:3],              is_key    last
//                                 pos_y[34:19], key_down[35],
//                                 keysym[51:36], mode_mouse[52]
//  cfg      in   wen              0 width, 1 height, 2 step               -         -
//
// An input beat is taken every cycle while the two-entry command queue has room.
// Each item yields zero to three events, sent one per cycle by the event
// generator while the sink is ready; an item that clicks and moves yields three.
// Reset is synchronous; the queue and output register come up empty.
// A stalled output fills the queue, then holds off the input side.
module joystick_key_to_remote_input_events
    import jkre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // joy_lines, key_code
    input  logic        i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // buttons, pos_x, pos_y, key_down, keysym, mode_mouse
    output logic        o_m_tuser,   // is_key
    output logic        o_m_tlast
);

    t_cmd front_cmd, q_cmd;
    logic push, pop, q_valid, q_full;

    jkre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .i_func     (i_s_tuser),
        .i_joy      (i_s_tdata[4:0]),
        .i_key      (i_s_tdata[12:5]),
        .i_full     (q_full),
        .o_ready    (o_s_tready),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    jkre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    jkre_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into full queue");

    a_queued_cmd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_cmd.num_ev != 2'd0))
        else $error("queued command without events");

    a_key_no_pointer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata[34:0] == 35'd0))
        else $error("key event carries pointer fields");

    a_ptr_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata[51:35] == 17'd0))
        else $error("pointer event carries key fields");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

@@ sim/jkre_event_checker.sv @@
// Event checker: predicts pointer and key events from observed beats and compares them.
`timescale 1ns / 100ps
module jkre_event_checker
    import jkre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // joy_lines, key_code
    input  logic        i_s_tuser,   // func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,   // buttons, pos_x, pos_y, key_down, keysym, mode_mouse
    input  logic        i_m_tuser,   // is_key
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int         JOY_UP     = 0;
    localparam int         JOY_DOWN   = 1;
    localparam int         JOY_LEFT   = 2;
    localparam int         JOY_RIGHT  = 3;
    localparam int         JOY_FIRE   = 4;
    localparam logic [2:0] NO_BUTTONS = 3'd0;
    localparam int         MAX_PRINTS = 30;

    typedef struct packed {
        logic        is_key;
        logic [2:0]  mask;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        key_down;
        logic [15:0] keysym;
        logic        mode;
        logic        last;
    } t_event;

    logic [15:0] scr_w;
    logic [15:0] scr_h;
    logic [7:0]  step;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic        mouse_on;
    logic        fire_down;
    t_event      expected_events[$];
    t_event      item_events[$];
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [15:0] move_back(input logic [15:0] v);
        return (v >= {8'd0, step}) ? v - {8'd0, step} : 16'd0;
    endfunction

    function automatic logic [15:0] move_fwd(input logic [15:0] v, input logic [15:0] size);
        logic [16:0] sum;
        sum = {1'b0, v} + {9'd0, step};
        if (sum >= {1'b0, size}) begin
            return (size == 16'd0) ? 16'd0 : size - 16'd1;
        end
        return sum[15:0];
    endfunction

    function automatic logic [15:0] keysym_of(input logic [7:0] code);
        case (code)
            KC_RETURN: return {8'd0, KC_RETURN};
            KC_DELETE: return KS_BACKSPACE;
            KC_UP:     return KS_UP;
            KC_DOWN:   return KS_DOWN;
            KC_LEFT:   return KS_LEFT;
            KC_RIGHT:  return KS_RIGHT;
            default: ;
        endcase
        // fold capitals to lower case, pass the rest of 0x20 to 0x60
        if (code >= 8'h41 && code <= 8'h5A) return {8'd0, code} + 16'h0020;
        if (code >= 8'h20 && code <= 8'h60) return {8'd0, code};
        return 16'd0;
    endfunction

    function automatic t_event pointer_event(input logic [2:0] mask);
        t_event ev;
        ev = '0;
        ev.mask  = mask;
        ev.pos_x = cur_x;
        ev.pos_y = cur_y;
        ev.mode  = mouse_on;
        return ev;
    endfunction

    function automatic t_event key_event(input logic down, input logic [15:0] sym);
        t_event ev;
        ev = '0;
        ev.is_key   = 1'b1;
        ev.key_down = down;
        ev.keysym   = sym;
        ev.mode     = mouse_on;
        return ev;
    endfunction

    function automatic void add_click(input logic [2:0] mask);
        item_events.push_back(pointer_event(mask));
        item_events.push_back(pointer_event(NO_BUTTONS));
    endfunction

    task automatic apply_config(input logic [1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_WIDTH:  scr_w = data;
            CFG_HEIGHT: scr_h = data;
            CFG_STEP:   step = data[7:0];
            default:    return;
        endcase
        cur_x = scr_w >> 1;
        cur_y = scr_h >> 1;
    endtask

    task automatic predict_item(input logic func, input logic [4:0] joy, input logic [7:0] key);
        logic        moved;
        logic [15:0] sym;
        t_event      ev;
        moved = 1'b0;
        item_events.delete();
        if (func == FUNC_JOY) begin
            if (joy != 5'd0) begin
                // directions apply in order up, down, left, right
                if (!joy[JOY_UP]) begin
                    cur_y = move_back(cur_y);
                    moved = 1'b1;
                end
                if (!joy[JOY_DOWN]) begin
                    cur_y = move_fwd(cur_y, scr_h);
                    moved = 1'b1;
                end
                if (!joy[JOY_LEFT]) begin
                    cur_x = move_back(cur_x);
                    moved = 1'b1;
                end
                if (!joy[JOY_RIGHT]) begin
                    cur_x = move_fwd(cur_x, scr_w);
                    moved = 1'b1;
                end
                if (!joy[JOY_FIRE]) begin
                    if (!fire_down) begin
                        add_click(BTN_LEFT);
                        fire_down = 1'b1;
                    end
                end else begin
                    fire_down = 1'b0;
                end
                if (moved) item_events.push_back(pointer_event(NO_BUTTONS));
            end
        end else if (key == KC_F7) begin
            mouse_on = !mouse_on;
        end else if (mouse_on) begin
            case (key)
                KC_UP: begin
                    cur_y = move_back(cur_y);
                    item_events.push_back(pointer_event(NO_BUTTONS));
                end
                KC_DOWN: begin
                    cur_y = move_fwd(cur_y, scr_h);
                    item_events.push_back(pointer_event(NO_BUTTONS));
                end
                KC_LEFT: begin
                    cur_x = move_back(cur_x);
                    item_events.push_back(pointer_event(NO_BUTTONS));
                end
                KC_RIGHT: begin
                    cur_x = move_fwd(cur_x, scr_w);
                    item_events.push_back(pointer_event(NO_BUTTONS));
                end
                KC_RETURN, KC_F1: add_click(BTN_LEFT);
                KC_F3:            add_click(BTN_MIDDLE);
                KC_F5:            add_click(BTN_RIGHT);
                default: ;
            endcase
        end else begin
            sym = keysym_of(key);
            if (sym != 16'd0) begin
                item_events.push_back(key_event(1'b1, sym));
                item_events.push_back(key_event(1'b0, sym));
            end
        end
        for (int i = 0; i < item_events.size(); i++) begin
            ev = item_events[i];
            ev.last = (i == item_events.size() - 1);
            expected_events.push_back(ev);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("%0t event check %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic compare_event();
        t_event want;
        if (expected_events.size() == 0) begin
            report_mismatch("beat with nothing expected", 64'(i_m_tdata), 64'd0);
            return;
        end
        want = expected_events.pop_front();
        check_field("is_key", 64'(i_m_tuser), 64'(want.is_key));
        check_field("buttons", 64'(i_m_tdata[2:0]), 64'(want.mask));
        check_field("pos_x", 64'(i_m_tdata[18:3]), 64'(want.pos_x));
        check_field("pos_y", 64'(i_m_tdata[34:19]), 64'(want.pos_y));
        check_field("key_down", 64'(i_m_tdata[35]), 64'(want.key_down));
        check_field("keysym", 64'(i_m_tdata[51:36]), 64'(want.keysym));
        check_field("mode_mouse", 64'(i_m_tdata[52]), 64'(want.mode));
        check_field("last", 64'(i_m_tlast), 64'(want.last));
    endtask

    // Sample at the edge: output beats first, since a beat taken now cannot
    // belong to an item accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scr_w     = RST_WIDTH;
            scr_h     = RST_HEIGHT;
            step      = RST_STEP;
            cur_x     = RST_WIDTH >> 1;
            cur_y     = RST_HEIGHT >> 1;
            mouse_on  = 1'b1;
            fire_down = 1'b0;
            expected_events.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) compare_event();
            if (i_cfg_wen) apply_config(i_cfg_idx, i_cfg_data);
            if (i_s_tvalid && i_s_tready) begin
                predict_item(i_s_tuser, i_s_tdata[4:0], i_s_tdata[12:5]);
            end
        end
        o_pending = expected_events.size();
    end

endmodule

@@ sim/joystick_key_to_remote_input_events_tb.sv @@
// Testbench top: drives joystick and key beats plus register writes, gives the verdict.
`timescale 1ns / 100ps
module joystick_key_to_remote_input_events_tb;
    import jkre_pkg::*;

    localparam logic [1:0] CFG_NONE      = 2'd3;   // index past the register list
    localparam int         SETTLE_CYCLES = 8;
    localparam int         LONG_HOLD     = 300;
    localparam int         PHASE_ITEMS   = 60;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_wen  = 1'b0;
    logic [1:0]  i_cfg_idx  = 2'd0;
    logic [15:0] i_cfg_data = 16'd0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = 16'd0;
    logic        i_s_tuser  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    int fail_count;
    int pending;
    int hold_requests = 0;
    int holds_served  = 0;
    int burst_left    = 0;
    bit fast_send     = 1'b0;
    bit fast_take     = 1'b0;

    joystick_key_to_remote_input_events dut (.*);

    jkre_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("joystick_key_to_remote_input_events_tb NOT OK");
        $finish;
    end

    // Event sink: random stalls per beat, bursts of no stall, and long hold-offs on request.
    initial begin : event_sink
        int wait_n;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) fast_take = !fast_take;
            wait_n = fast_take ? 0 : $urandom_range(0, 15);
            if (hold_requests != holds_served) begin
                holds_served++;
                wait_n = LONG_HOLD;
            end
            if (wait_n > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic func, input logic [4:0] joy, input logic [7:0] key);
        int gap;
        if ($urandom_range(0, 15) == 0) fast_send = !fast_send;
        gap = (fast_send || burst_left > 0) ? 0 : $urandom_range(0, 15);
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'd0, key, joy};
        i_s_tuser  <= func;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted event has been taken.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] w, input logic [15:0] h,
                                  input logic [7:0] s);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_STEP, {8'd0, s});
        i_cfg_wen <= 1'b0;
    endtask

    task automatic pick_item(output logic func, output logic [4:0] joy, output logic [7:0] key);
        int   kind;
        logic fire;
        kind = $urandom_range(0, 19);
        fire = 1'($urandom_range(0, 1));
        func = FUNC_JOY;
        joy  = 5'($urandom_range(0, 31));
        key  = 8'($urandom_range(0, 255));
        if (kind < 4) begin
            // keep the fully random joystick pattern
        end else if (kind < 7) begin
            joy = {fire, 4'hF ^ (4'd1 << $urandom_range(0, 3))};
        end else if (kind < 9) begin
            joy = {fire, 4'hF};
        end else if (kind < 18) begin
            func = FUNC_KEY;
            case ($urandom_range(0, 10))
                0: key = KC_UP;
                1: key = KC_DOWN;
                2: key = KC_LEFT;
                3: key = KC_RIGHT;
                4: key = KC_RETURN;
                5: key = KC_F1;
                6: key = KC_F3;
                7: key = KC_F5;
                8: key = KC_DELETE;
                default: key = 8'($urandom_range(8'h20, 8'h60));
            endcase
        end else if (kind < 19) begin
            func = FUNC_KEY;
        end else begin
            func = FUNC_KEY;
            key  = KC_F7;
        end
    endtask

    task automatic run_random(input int count, input bit with_hold);
        int         sent;
        bit         hold_done;
        logic       func;
        logic [4:0] joy;
        logic [7:0] key;
        sent      = 0;
        hold_done = 1'b0;
        while (sent < count) begin
            pick_item(func, joy, key);
            if (with_hold && !hold_done && sent >= count / 2) begin
                // stall the sink and keep offering beats so the queue fills
                hold_requests++;
                burst_left = 16;
                hold_done  = 1'b1;
            end
            send_item(func, joy, key);
            if (!(func == FUNC_JOY && joy == 5'd0) && !(func == FUNC_KEY && key == KC_F7)) begin
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // joystick: idle, all released, each direction, fire press, held, all at once
        send_item(FUNC_JOY, 5'h00, 8'hFF);
        send_item(FUNC_JOY, 5'h1F, 8'h00);
        send_item(FUNC_JOY, 5'h1E, 8'h00);
        send_item(FUNC_JOY, 5'h1D, 8'h00);
        send_item(FUNC_JOY, 5'h1B, 8'h00);
        send_item(FUNC_JOY, 5'h17, 8'h00);
        send_item(FUNC_JOY, 5'h0F, 8'h00);
        send_item(FUNC_JOY, 5'h0F, 8'h00);
        send_item(FUNC_JOY, 5'h10, 8'h00);
        send_item(FUNC_JOY, 5'h00, 8'h00);
        send_item(FUNC_JOY, 5'h00, 8'h00);
        // mouse mode keys, an unlisted key, toggle to keyboard mode, keyboard keys, toggle back
        send_item(FUNC_KEY, 5'h1F, KC_UP);
        send_item(FUNC_KEY, 5'h1F, KC_DOWN);
        send_item(FUNC_KEY, 5'h00, KC_LEFT);
        send_item(FUNC_KEY, 5'h00, KC_RIGHT);
        send_item(FUNC_KEY, 5'h00, KC_RETURN);
        send_item(FUNC_KEY, 5'h00, KC_F1);
        send_item(FUNC_KEY, 5'h00, KC_F3);
        send_item(FUNC_KEY, 5'h00, KC_F5);
        send_item(FUNC_KEY, 5'h00, 8'h41);
        send_item(FUNC_KEY, 5'h00, KC_F7);
        send_item(FUNC_KEY, 5'h00, 8'h41);
        send_item(FUNC_KEY, 5'h00, 8'h5A);
        send_item(FUNC_KEY, 5'h00, KC_DELETE);
        send_item(FUNC_KEY, 5'h00, 8'h60);
        send_item(FUNC_KEY, 5'h00, 8'hFF);
        send_item(FUNC_KEY, 5'h00, KC_F7);
        run_random(PHASE_ITEMS, 1'b0);

        drain();
        apply_settings(16'hFFFF, 16'hFFFF, 8'hFF);
        run_random(PHASE_ITEMS, 1'b1);

        drain();
        apply_settings(16'd1, 16'd1, 8'd1);
        run_random(PHASE_ITEMS, 1'b0);

        // zero screen size and zero step
        drain();
        apply_settings(16'd0, 16'd0, 8'd0);
        run_random(PHASE_ITEMS, 1'b0);

        drain();
        apply_settings(16'd37, 16'd21, 8'hFF);
        run_random(PHASE_ITEMS, 1'b1);

        drain();
        apply_settings(RST_WIDTH, RST_HEIGHT, RST_STEP);
        run_random(PHASE_ITEMS / 2, 1'b0);
        // pause until all events are out, then write an index that must not recenter
        drain();
        write_reg(CFG_NONE, 16'($urandom_range(0, 65535)));
        i_cfg_wen <= 1'b0;
        run_random(PHASE_ITEMS / 2, 1'b0);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("joystick_key_to_remote_input_events_tb OK");
        end else begin
            $display("joystick_key_to_remote_input_events_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/jkre_pkg.sv
design/jkre_front.sv
design/jkre_fifo.sv
design/jkre_back.sv
design/joystick_key_to_remote_input_events.sv
sim/jkre_event_checker.sv
sim/joystick_key_to_remote_input_events_tb.sv
